/* rtl/core/bmp_rle_pixel_decoder_core_defines.svh */
// Assertion macros shared by the bitmap RLE decoder modules.
`ifndef BMP_RLE_PIXEL_DECODER_CORE_DEFINES_SVH
`define BMP_RLE_PIXEL_DECODER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BMPRLE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmprle assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BMPRLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bmprle assertion failed");

`endif

/* rtl/core/bmprle_pkg.sv */
// Types, constants and helpers shared by the bitmap RLE decoder modules.
package bmprle_pkg;

    localparam int C_MAX_WIDTH  = 4096;
    localparam int C_MAX_HEIGHT = 4096;

    localparam logic [11:0] C_POS_LIMIT = 12'hFFF;

    localparam logic [7:0] C_ESC_EOL   = 8'h00;
    localparam logic [7:0] C_ESC_EOB   = 8'h01;
    localparam logic [7:0] C_ESC_DELTA = 8'h02;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_COLOR,
        PH_ESCAPE,
        PH_ABS,
        PH_PAD,
        PH_DX,
        PH_DY,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        CFG_RLE4_MODE,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_BOTTOM_UP
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] row_pos;
        logic [15:0] column_pos;
        logic [7:0]  length;
        logic [7:0]  even_index;
        logic [7:0]  odd_index;
        logic        end_of_bitmap;
    } t_span;

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

endpackage

/* rtl/core/bmp_rle_pixel_decoder_core.sv */
// Top level of the bitmap RLE8/RLE4 pixel-stream decoder.
//
// The slave stream carries one compressed byte per transfer in tdata and the
// first-byte flag in tuser; a set flag restarts position, phase and parity.
// The master stream carries one span per transfer: row, start column, pixel
// count and the two alternating palette indices in tdata, with the end of
// bitmap and out-of-range flags in tuser. Bytes that complete no span give
// no master transfer.
// The configuration port must be written only while the stream is quiet;
// the block itself does not enforce this. The mode register is taken with
// every byte, the geometry registers at the output stage.
// A byte is taken every cycle unless the slave side is stalled. A span
// passes from the phase machine into the span register, then through the
// row mapping and range check into the output register.
// A stalled receiver holds the output register; the span register keeps one
// further span and the slave side stops taking bytes only when both are full.
// Reset restores the configuration defaults, empties both registers and
// returns the phase machine to waiting for a count byte.
`include "bmp_rle_pixel_decoder_core_defines.svh"

module bmp_rle_pixel_decoder_core
    import bmprle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // stream_byte
    input  logic [0:0]  s_axis_tuser,   // first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // span_row, span_column, span_length,
                                        // even_index, odd_index
    output logic [1:0]  m_axis_tuser,   // end_of_bitmap, out_of_range
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic        r_rle4_mode;
    logic [12:0] r_image_width;
    logic [12:0] r_image_height;
    logic        r_bottom_up;

    logic        r_m_valid;
    logic [47:0] r_m_data;
    logic [1:0]  r_m_user;
    logic [47:0] n_m_data;
    logic [1:0]  n_m_user;

    logic        w_span_valid;
    logic        w_span_take;
    t_span       w_span;
    logic [12:0] w_width;
    logic [12:0] w_height;

    bmprle_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_first      (s_axis_tuser[0]),
        .i_rle4_mode  (r_rle4_mode),
        .i_span_take  (w_span_take),
        .o_span_valid (w_span_valid),
        .o_span       (w_span)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle4_mode    <= 1'b0;
            r_image_width  <= 13'd1;
            r_image_height <= 13'd1;
            r_bottom_up    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_RLE4_MODE:    r_rle4_mode    <= i_cfg_data[0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                CFG_BOTTOM_UP:    r_bottom_up    <= i_cfg_data[0];
                default:          r_rle4_mode    <= r_rle4_mode;
            endcase
        end
    end

    always_comb begin
        if (r_image_width == 13'd0) begin
            w_width = 13'd1;
        end else if (r_image_width > 13'(C_MAX_WIDTH)) begin
            w_width = 13'(C_MAX_WIDTH);
        end else begin
            w_width = r_image_width;
        end
        if (r_image_height == 13'd0) begin
            w_height = 13'd1;
        end else if (r_image_height > 13'(C_MAX_HEIGHT)) begin
            w_height = 13'(C_MAX_HEIGHT);
        end else begin
            w_height = r_image_height;
        end
    end

    always_comb begin
        logic        oor;
        logic [12:0] row13;
        logic [11:0] row_out;
        logic [11:0] col_out;
        logic [16:0] col_end;

        oor     = 1'b0;
        row13   = 13'd0;
        row_out = C_POS_LIMIT;
        if (w_span.row_pos >= {3'd0, w_height}) begin
            oor = 1'b1;
        end else begin
            row13 = r_bottom_up ? (w_height - 13'd1 - w_span.row_pos[12:0])
                                : w_span.row_pos[12:0];
            if (row13[12]) begin
                oor = 1'b1;
            end else begin
                row_out = row13[11:0];
            end
        end
        if (w_span.column_pos > {4'd0, C_POS_LIMIT}) begin
            oor     = 1'b1;
            col_out = C_POS_LIMIT;
        end else begin
            col_out = w_span.column_pos[11:0];
        end
        col_end = {1'b0, w_span.column_pos} + {9'd0, w_span.length};
        if (col_end > {4'd0, w_width}) begin
            oor = 1'b1;
        end
        n_m_data = {w_span.odd_index, w_span.even_index, w_span.length, col_out, row_out};
        n_m_user = {oor, w_span.end_of_bitmap};
    end

    assign w_span_take = w_span_valid && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_span_take) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_span_take) begin
            r_m_data <= n_m_data;
            r_m_user <= n_m_user;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    `BMPRLE_ASSERT_SAME(a_eob_zero_length, m_axis_tvalid && m_axis_tuser[0],
                        m_axis_tdata[31:24] == 8'd0)
    `BMPRLE_ASSERT_SAME(a_full_blocks_input, w_span_valid && m_axis_tvalid && !m_axis_tready,
                        !s_axis_tready)
    `BMPRLE_ASSERT_NEXT(a_span_moves_on, w_span_valid && !m_axis_tvalid, m_axis_tvalid)

endmodule

/* rtl/core/bmprle_decode.sv */
// Byte-level RLE phase machine with position tracking and a span register.
`include "bmp_rle_pixel_decoder_core_defines.svh"

module bmprle_decode
    import bmprle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    input  logic       i_rle4_mode,
    input  logic       i_span_take,
    output logic       o_span_valid,
    output t_span      o_span
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_run_count, n_run_count;
    logic [7:0]  r_abs_left, n_abs_left;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [7:0]  r_dcol, n_dcol;
    logic        r_par, n_par;
    logic        r_span_valid;
    t_span       r_span;

    logic        w_accept;
    logic        w_fire;
    t_span       w_span;

    assign o_s_tready   = !r_span_valid || i_span_take;
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign o_span_valid = r_span_valid;
    assign o_span       = r_span;

    always_comb begin
        t_phase      ph;
        logic [7:0]  rc;
        logic [7:0]  al;
        logic [7:0]  dc;
        logic [15:0] col;
        logic [15:0] row;
        logic        par;
        logic [7:0]  len;

        ph  = i_first ? PH_COUNT : r_phase;
        rc  = i_first ? 8'd0 : r_run_count;
        al  = i_first ? 8'd0 : r_abs_left;
        dc  = i_first ? 8'd0 : r_dcol;
        col = i_first ? 16'd0 : r_col;
        row = i_first ? 16'd0 : r_row;
        par = i_first ? 1'b0 : r_par;
        len = 8'd0;

        n_phase     = ph;
        n_run_count = rc;
        n_abs_left  = al;
        n_col       = col;
        n_row       = row;
        n_dcol      = dc;
        n_par       = ~par;
        w_fire      = 1'b0;

        w_span.row_pos       = row;
        w_span.column_pos    = col;
        w_span.even_index    = i_rle4_mode ? {4'd0, i_byte[7:4]} : i_byte;
        w_span.odd_index     = i_rle4_mode ? {4'd0, i_byte[3:0]} : i_byte;
        w_span.end_of_bitmap = 1'b0;

        unique case (ph)
            PH_COUNT: begin
                if (i_byte != 8'd0) begin
                    n_run_count = i_byte;
                    n_phase     = PH_COLOR;
                end else begin
                    n_phase = PH_ESCAPE;
                end
            end
            PH_COLOR: begin
                len     = rc;
                w_fire  = 1'b1;
                n_col   = sat16({1'b0, col} + {9'd0, rc});
                n_phase = PH_COUNT;
            end
            PH_ESCAPE: begin
                unique case (i_byte)
                    C_ESC_EOL: begin
                        n_col   = 16'd0;
                        n_row   = sat16({1'b0, row} + 17'd1);
                        n_phase = PH_COUNT;
                    end
                    C_ESC_EOB: begin
                        w_fire               = 1'b1;
                        w_span.even_index    = 8'd0;
                        w_span.odd_index     = 8'd0;
                        w_span.end_of_bitmap = 1'b1;
                        n_phase              = PH_DONE;
                    end
                    C_ESC_DELTA: begin
                        n_phase = PH_DX;
                    end
                    default: begin
                        n_abs_left = i_byte;
                        n_phase    = PH_ABS;
                    end
                endcase
            end
            PH_ABS: begin
                if (al == 8'd0) begin
                    len = 8'd0;
                end else if (i_rle4_mode && (al >= 8'd2)) begin
                    len = 8'd2;
                end else begin
                    len = 8'd1;
                end
                w_fire     = 1'b1;
                n_col      = sat16({1'b0, col} + {9'd0, len});
                n_abs_left = al - len;
                if (al == len) begin
                    n_phase = n_par ? PH_PAD : PH_COUNT;
                end
            end
            PH_PAD: begin
                n_phase = PH_COUNT;
            end
            PH_DX: begin
                n_dcol  = i_byte;
                n_phase = PH_DY;
            end
            PH_DY: begin
                n_col   = sat16({1'b0, col} + {9'd0, dc});
                n_row   = sat16({1'b0, row} + {9'd0, i_byte});
                n_phase = PH_COUNT;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_COUNT;
            end
        endcase

        w_span.length = len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count  <= 8'd0;
            r_abs_left   <= 8'd0;
            r_col        <= 16'd0;
            r_row        <= 16'd0;
            r_dcol       <= 8'd0;
            r_par        <= 1'b0;
            r_span_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_run_count <= n_run_count;
                r_abs_left  <= n_abs_left;
                r_col       <= n_col;
                r_row       <= n_row;
                r_dcol      <= n_dcol;
                r_par       <= n_par;
            end
            if (w_accept && w_fire) begin
                r_span_valid <= 1'b1;
            end else if (i_span_take) begin
                r_span_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_fire) begin
            r_span <= w_span;
        end
    end

    `BMPRLE_ASSERT_SAME(a_abs_left_nonzero, r_phase == PH_ABS, r_abs_left != 8'd0)
    `BMPRLE_ASSERT_SAME(a_run_count_nonzero, r_phase == PH_COLOR, r_run_count != 8'd0)
    `BMPRLE_ASSERT_NEXT(a_done_is_silent, w_accept && (r_phase == PH_DONE) && !i_first,
                        !r_span_valid)

endmodule

/* dv/tb.sv */
// Self-checking testbench for the bitmap RLE8/RLE4 pixel-stream decoder core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmprle_pkg::*;

    localparam logic [7:0] ESC_MARK   = 8'h00;
    localparam int         LONG_HOLD  = 300;
    localparam int         PHASE_SIZE = 50;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  length;
        logic [7:0]  even_index;
        logic [7:0]  odd_index;
        logic        eob;
        logic        oor;
    } t_span_fields;

    class span_scoreboard;
        bit           rle4;
        bit [12:0]    width_cfg;
        bit [12:0]    height_cfg;
        bit           bottom_up;
        t_phase       phase;
        bit [7:0]     run_len;
        bit [7:0]     abs_left;
        bit [7:0]     dx;
        int unsigned  column;
        int unsigned  row;
        bit           parity;
        t_span_fields expected_spans[$];
        int           mismatches;

        function new();
            rle4       = 1'b0;
            width_cfg  = 13'd1;
            height_cfg = 13'd1;
            bottom_up  = 1'b1;
            phase      = PH_COUNT;
            run_len    = '0;
            abs_left   = '0;
            dx         = '0;
            column     = 0;
            row        = 0;
            parity     = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [12:0] value);
            case (idx)
                CFG_RLE4_MODE:    rle4 = value[0];
                CFG_IMAGE_WIDTH:  width_cfg = value;
                CFG_IMAGE_HEIGHT: height_cfg = value;
                CFG_BOTTOM_UP:    bottom_up = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_size(bit [12:0] v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return 32'(v);
        endfunction

        function int unsigned sat_pos(int unsigned v);
            return (v > 65535) ? 65535 : v;
        endfunction

        function void emit_span(int unsigned len, bit [7:0] ev, bit [7:0] od, bit eob);
            int unsigned  w;
            int unsigned  h;
            int unsigned  r;
            int unsigned  c;
            t_span_fields s;
            w = clamp_size(width_cfg, C_MAX_WIDTH);
            h = clamp_size(height_cfg, C_MAX_HEIGHT);
            s.oor = 1'b0;
            if (row >= h) begin
                s.oor = 1'b1;
                r = 4095;
            end else begin
                r = bottom_up ? (h - 1 - row) : row;
                if (r > 4095) begin
                    s.oor = 1'b1;
                    r = 4095;
                end
            end
            c = column;
            if (c > 4095) begin
                s.oor = 1'b1;
                c = 4095;
            end
            if (column + len > w) s.oor = 1'b1;
            s.row        = r[11:0];
            s.column     = c[11:0];
            s.length     = len[7:0];
            s.even_index = ev;
            s.odd_index  = od;
            s.eob        = eob;
            expected_spans.push_back(s);
        endfunction

        function void paint(int unsigned len, bit [7:0] b);
            if (rle4) emit_span(len, {4'h0, b[7:4]}, {4'h0, b[3:0]}, 1'b0);
            else emit_span(len, b, b, 1'b0);
            column = sat_pos(column + len);
        endfunction

        function void note_byte(bit [7:0] b, bit first);
            int unsigned len;
            if (first) begin
                phase    = PH_COUNT;
                column   = 0;
                row      = 0;
                parity   = 1'b0;
                run_len  = '0;
                abs_left = '0;
                dx       = '0;
            end
            parity ^= 1'b1;
            case (phase)
                PH_COUNT: begin
                    if (b != 0) begin
                        run_len = b;
                        phase   = PH_COLOR;
                    end else begin
                        phase = PH_ESCAPE;
                    end
                end
                PH_COLOR: begin
                    paint(32'(run_len), b);
                    phase = PH_COUNT;
                end
                PH_ESCAPE: begin
                    if (b == C_ESC_EOL) begin
                        column = 0;
                        row    = sat_pos(row + 1);
                        phase  = PH_COUNT;
                    end else if (b == C_ESC_EOB) begin
                        emit_span(0, 8'h00, 8'h00, 1'b1);
                        phase = PH_DONE;
                    end else if (b == C_ESC_DELTA) begin
                        phase = PH_DX;
                    end else begin
                        abs_left = b;
                        phase    = PH_ABS;
                    end
                end
                PH_ABS: begin
                    len = (rle4 && abs_left >= 2) ? 2 : 1;
                    if (abs_left == 0) len = 0;
                    paint(len, b);
                    abs_left = abs_left - len[7:0];
                    if (abs_left == 0) phase = parity ? PH_PAD : PH_COUNT;
                end
                PH_PAD: phase = PH_COUNT;
                PH_DX: begin
                    dx    = b;
                    phase = PH_DY;
                end
                PH_DY: begin
                    column = sat_pos(column + dx);
                    row    = sat_pos(row + b);
                    phase  = PH_COUNT;
                end
                default: ;
            endcase
        endfunction

        function void check_span(logic [47:0] data, logic [1:0] user);
            t_span_fields got;
            t_span_fields want;
            got.row        = data[11:0];
            got.column     = data[23:12];
            got.length     = data[31:24];
            got.even_index = data[39:32];
            got.odd_index  = data[47:40];
            got.eob        = user[0];
            got.oor        = user[1];
            if (expected_spans.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected span row %0d col %0d len %0d eob %0b oor %0b",
                             got.row, got.column, got.length, got.eob, got.oor);
                return;
            end
            want = expected_spans.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("tb: span mismatch at %0t", $realtime);
                    $display("    expected row %0d col %0d len %0d even %0h odd %0h eob %0b oor %0b",
                             want.row, want.column, want.length, want.even_index,
                             want.odd_index, want.eob, want.oor);
                    $display("    actual   row %0d col %0d len %0d even %0h odd %0h eob %0b oor %0b",
                             got.row, got.column, got.length, got.even_index,
                             got.odd_index, got.eob, got.oor);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // stream_byte
    logic [0:0]  s_axis_tuser = 1'b0;    // first_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // span_row, span_column, span_length,
                                         // even_index, odd_index
    logic [1:0]  m_axis_tuser;           // end_of_bitmap, out_of_range
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [12:0] i_cfg_data = 13'd0;

    span_scoreboard sb = new();

    int  burst_left = 0;
    int  sent_count = 0;
    int  img_bytes = 0;
    bit  cfg_rle4 = 1'b0;
    bit  long_hold_go = 1'b0;
    int  hold_count = 0;
    int  rx_mode = 0;
    int  rx_left = 0;

    bmp_rle_pixel_decoder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_span(m_axis_tdata, m_axis_tuser);
            if (i_cfg_we) sb.write_reg(t_cfg_index'(i_cfg_index), i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tuser[0]);
        end
    end

    // The receiver runs its own stall pattern, apart from one long hold-off.
    always @(negedge i_clk) begin
        if (long_hold_go && hold_count < LONG_HOLD) begin
            hold_count++;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(10, 200);
            end
            rx_left--;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((rx_left % 8) < 4);
            endcase
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 4);
            endcase
            burst_left = $urandom_range(1, 64);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        burst_left--;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    task automatic put(input logic [7:0] b);
        push_byte(b, img_bytes == 0);
        img_bytes++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.expected_spans.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input bit rle4, input int w, input int h, input bit bu);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RLE4_MODE;
        i_cfg_data  <= {12'd0, rle4};
        @(negedge i_clk);
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= w[12:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= h[12:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_BOTTOM_UP;
        i_cfg_data  <= {12'd0, bu};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_rle4 = rle4;
    endtask

    task automatic send_image(input int n_ops);
        int k;
        int n;
        int op;
        img_bytes = 0;
        for (k = 0; k < n_ops; k++) begin
            op = $urandom_range(0, 99);
            if (op < 45) begin
                if ($urandom_range(0, 9) == 0) put(8'($urandom_range(1, 255)));
                else put(8'($urandom_range(1, 12)));
                put(8'($urandom_range(0, 255)));
            end else if (op < 65) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 10);
                put(ESC_MARK);
                put(n[7:0]);
                repeat (cfg_rle4 ? (n + 1) / 2 : n) put(8'($urandom_range(0, 255)));
                if (img_bytes % 2 == 1) put(8'($urandom_range(0, 255)));
            end else if (op < 80) begin
                put(ESC_MARK);
                put(C_ESC_EOL);
            end else if (op < 95) begin
                put(ESC_MARK);
                put(C_ESC_DELTA);
                put(($urandom_range(0, 19) == 0) ? 8'hFF : 8'($urandom_range(0, 8)));
                put(($urandom_range(0, 19) == 0) ? 8'hFF : 8'($urandom_range(0, 2)));
            end else if (op < 98) begin
                // A broken sequence: the next image restarts in the middle of it.
                if ($urandom_range(0, 1)) put(8'($urandom_range(1, 255)));
                else put(ESC_MARK);
                return;
            end else begin
                drain();
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            put(ESC_MARK);
            put(C_ESC_EOB);
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    endtask

    // Deltas carry both positions to saturation before one more run and the end of the bitmap.
    task automatic send_drift_image();
        img_bytes = 0;
        repeat (260) begin
            put(ESC_MARK);
            put(C_ESC_DELTA);
            put(8'hFF);
            put(8'hFF);
        end
        put(8'h03);
        put(8'($urandom_range(0, 255)));
        put(ESC_MARK);
        put(C_ESC_EOB);
    endtask

    initial begin
        #10ms;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        int p;
        int phase_end;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        img_bytes = 0;
        put(8'h01);
        put(8'hFF);
        put(ESC_MARK);
        put(C_ESC_EOB);
        push_byte(8'h55, 1'b0);

        configure(1'b1, 4096, 1, 1'b1);
        img_bytes = 0;
        put(8'hFF);
        put(8'h5A);
        put(ESC_MARK);
        put(8'h05);
        put(8'hA1);
        put(8'hB2);
        put(8'hC3);
        put(8'h00);
        put(ESC_MARK);
        put(C_ESC_DELTA);
        put(8'hFF);
        put(8'hFF);
        put(ESC_MARK);
        put(C_ESC_EOL);
        put(ESC_MARK);
        put(C_ESC_EOB);

        for (p = 0; p < 8; p++) begin
            case (p)
                0: configure(1'b0, 4096, 4096, 1'b1);
                1: configure(1'b1, 1, 1, 1'b0);
                5: configure(1'($urandom_range(0, 1)), 0, 0, 1'($urandom_range(0, 1)));
                6: configure(1'($urandom_range(0, 1)), 8191, 5000, 1'b1);
                default: configure(1'($urandom_range(0, 1)), $urandom_range(1, 64),
                                   $urandom_range(1, 32), 1'($urandom_range(0, 1)));
            endcase
            if (p == 1) long_hold_go = 1'b1;
            if (p == 3) send_drift_image();
            phase_end = sent_count + PHASE_SIZE;
            while (sent_count < phase_end) begin
                if ($urandom_range(0, 9) == 0) send_noise($urandom_range(5, 30));
                else send_image($urandom_range(3, 25));
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_spans.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bmprle_pkg.sv
rtl/core/bmprle_decode.sv
rtl/core/bmp_rle_pixel_decoder_core.sv
dv/tb.sv
